[hw/rtl/wtpq_pkg.sv]
package wtpq_pkg;

  // fixed field widths of the request and result channels, and the default capacity
  localparam int TIME_BITS    = 16;
  localparam int ID_BITS      = 8;
  localparam int CAPACITY_DEF = 16;
  localparam int ENTRY_BITS   = TIME_BITS + ID_BITS;

  // request type codes as they arrive on the input channel
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_REMOVE,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_NOT_FOUND,
    ST_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PSCAN,
    BK_PUT,
    BK_RPASS,
    BK_HEAD,
    BK_HWAIT
  } back_state_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                  op;
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS-1:0] key;
    logic [ID_BITS-1:0]   tag;
  } cmd_t;

  // key a is due strictly sooner than key b, wrap point at base
  function automatic logic sooner(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b,
                                  logic [TIME_BITS-1:0] base);
    logic a_hi;
    logic b_hi;
    a_hi = (a >= base);
    b_hi = (b >= base);
    if (a_hi != b_hi) begin
      return a_hi;
    end
    return (a < b);
  endfunction

endpackage

[hw/rtl/wtpq_ram.sv]
module wtpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/wtpq_front.sv]
module wtpq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [wtpq_pkg::TIME_BITS-1:0] in_now_base,
  input  logic [wtpq_pkg::TIME_BITS-1:0] in_delay,
  input  logic [wtpq_pkg::ID_BITS-1:0]   in_handler_id,
  output logic                          q_push,
  output wtpq_pkg::cmd_t                q_data,
  input  logic                          q_full
);

  import wtpq_pkg::*;

  logic st_valid_r;
  logic st_valid_nxt;
  cmd_t st_cmd_r;
  cmd_t st_cmd_nxt;
  logic accept;

  assign busy   = st_valid_r && q_full;
  assign accept = start && !busy;
  assign q_push = st_valid_r && !q_full;
  assign q_data = st_cmd_r;

  always_comb begin
    st_valid_nxt = st_valid_r;
    st_cmd_nxt   = st_cmd_r;
    if (accept) begin
      st_valid_nxt    = 1'b1;
      st_cmd_nxt.base = in_now_base;
      st_cmd_nxt.key  = in_now_base + in_delay;
      st_cmd_nxt.tag  = in_handler_id;
      case (in_req_type)
        REQ_PUSH:   st_cmd_nxt.op = OP_PUSH;
        REQ_POP:    st_cmd_nxt.op = OP_POP;
        REQ_REMOVE: st_cmd_nxt.op = OP_REMOVE;
        default:    st_cmd_nxt.op = OP_NOP;
      endcase
    end else if (q_push) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
    st_cmd_r <= st_cmd_nxt;
  end

endmodule

[hw/rtl/wtpq_cmd_q.sv]
module wtpq_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wtpq_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output wtpq_pkg::cmd_t pop_data,
  output logic           empty
);

  import wtpq_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       slot_r [DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = (cnt_r == 2'(DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/wtpq_back.sv]
module wtpq_back #(
  parameter int CAPACITY = wtpq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  wtpq_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic                            out_head_valid,
  output logic [wtpq_pkg::TIME_BITS-1:0]  out_head_due,
  output logic [wtpq_pkg::ID_BITS-1:0]    out_head_handler,
  output logic [$clog2(CAPACITY+1)-1:0]   out_entry_count
);

  import wtpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [IDX_W-1:0]     pos_r;
  logic [IDX_W-1:0]     pos_nxt;
  logic                 found_r;
  logic                 found_nxt;
  status_t              status_r;
  status_t              status_nxt;
  cmd_t                 cur_r;
  cmd_t                 cur_nxt;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 head_valid_r;
  logic                 head_valid_nxt;
  logic [TIME_BITS-1:0] head_due_r;
  logic [TIME_BITS-1:0] head_due_nxt;
  logic [ID_BITS-1:0]   head_tag_r;
  logic [ID_BITS-1:0]   head_tag_nxt;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENTRY_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0]  rd_due;
  logic [ID_BITS-1:0]    rd_tag;
  logic                  last_idx;
  logic                  hit;

  wtpq_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_due   = rd_data[ID_BITS +: TIME_BITS];
  assign rd_tag   = rd_data[ID_BITS-1:0];
  assign last_idx = ((CNT_W'(pos_r) + CNT_W'(1)) == count_r);
  assign hit      = (rd_due == cur_r.key) && (rd_tag == cur_r.tag);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = 1'b0;
    head_valid_nxt = head_valid_r;
    head_due_nxt   = head_due_r;
    head_tag_nxt   = head_tag_r;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = {cur_r.key, cur_r.tag};
    rd_en          = 1'b0;
    rd_addr        = pos_r;

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cur_nxt    = cmd;
          status_nxt = ST_DONE;
          case (cmd.op)
            OP_PUSH: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = BK_HEAD;
              end else if (count_r == '0) begin
                pos_nxt   = '0;
                state_nxt = BK_PUT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(count_r - CNT_W'(1));
                pos_nxt   = IDX_W'(count_r);
                state_nxt = BK_PSCAN;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
              state_nxt = BK_HEAD;
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = BK_HEAD;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                pos_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = BK_RPASS;
              end
            end
            default: begin
              state_nxt = BK_HEAD;
            end
          endcase
        end
      end
      BK_PSCAN: begin
        // rd_data holds the entry just below pos
        wr_en = 1'b1;
        if (!sooner(cur_r.key, rd_due, cur_r.base)) begin
          wr_data = rd_data;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r > IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos_r - IDX_W'(2);
          end else begin
            state_nxt = BK_PUT;
          end
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = BK_HEAD;
        end
      end
      BK_PUT: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = BK_HEAD;
      end
      BK_RPASS: begin
        // rd_data holds entry pos; once matched, each later entry moves down one
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = pos_r - IDX_W'(1);
          wr_data = rd_data;
        end else if (hit) begin
          found_nxt = 1'b1;
        end
        if (!last_idx) begin
          rd_en   = 1'b1;
          rd_addr = pos_r + IDX_W'(1);
          pos_nxt = pos_r + IDX_W'(1);
        end else begin
          if (found_r || hit) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
          state_nxt = BK_HEAD;
        end
      end
      BK_HEAD: begin
        if (count_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(count_r - CNT_W'(1));
          state_nxt = BK_HWAIT;
        end else begin
          out_valid_nxt  = 1'b1;
          head_valid_nxt = 1'b0;
          head_due_nxt   = '0;
          head_tag_nxt   = '0;
          state_nxt      = BK_IDLE;
        end
      end
      BK_HWAIT: begin
        out_valid_nxt  = 1'b1;
        head_valid_nxt = 1'b1;
        head_due_nxt   = rd_due;
        head_tag_nxt   = rd_tag;
        state_nxt      = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    cur_r        <= cur_nxt;
    head_valid_r <= head_valid_nxt;
    head_due_r   <= head_due_nxt;
    head_tag_r   <= head_tag_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_head_valid   = head_valid_r;
  assign out_head_due     = head_due_r;
  assign out_head_handler = head_tag_r;
  assign out_entry_count  = count_r;

endmodule

[hw/rtl/wtpq_core_top.sv]
// wrapping time priority queue: sorted timer list, soonest entry reported as head
// request channel: start with in_req_type / in_now_base / in_delay / in_handler_id,
//   taken on a clock edge where start is high and busy is low
//   req 0 push (due = now_base + delay, wrap-aware order), 1 pop head,
//   2 remove first matching (due, id) entry, 3 no change
// result channel: out_valid strobes for one cycle with out_status, out_head_valid,
//   out_head_due, out_head_handler and out_entry_count; the receiver cannot stall,
//   so every result must be captured in its strobe cycle
// latency, from the edge that takes a request to the edge that takes its result:
//   4 cycles when the queue is empty afterwards and no walk was needed, 5 for pop
//   and no-op otherwise, up to CAPACITY + 5 for push and remove, set by the back end
//   walking the entry ram one slot per cycle
// throughput: the back end picks up the next request in the strobe cycle, so it
//   spends 2 to 3 cycles on a pop or no-op and up to CAPACITY + 3 on a push or remove
// one request is worked at a time; a two-deep command queue and a front stage
//   take up to three further requests while the back end is busy, then busy rises
// reset: synchronous, active low; the queue comes up empty, no result is pending
// the entry ram has no clearing pass: only slots below the count are ever read
module wrapping_time_priority_queue_core #(
  parameter int CAPACITY = wtpq_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [wtpq_pkg::TIME_BITS-1:0] in_now_base,
  input  logic [wtpq_pkg::TIME_BITS-1:0] in_delay,
  input  logic [wtpq_pkg::ID_BITS-1:0]   in_handler_id,
  // result channel
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic                           out_head_valid,
  output logic [wtpq_pkg::TIME_BITS-1:0] out_head_due,
  output logic [wtpq_pkg::ID_BITS-1:0]   out_head_handler,
  output logic [$clog2(CAPACITY+1)-1:0]  out_entry_count
);

  import wtpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // front stage to command queue
  logic q_push;
  cmd_t q_wdata;
  logic q_full;
  // command queue to back end
  logic q_pop;
  cmd_t q_rdata;
  logic q_empty;

  // front: takes requests, forms the due time, classifies the request type
  wtpq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_now_base   (in_now_base),
    .in_delay      (in_delay),
    .in_handler_id (in_handler_id),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  // short queue decoupling front and back
  wtpq_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: insert / remove walk over the entry ram, head readout, result strobe
  wtpq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (!q_empty),
    .cmd              (q_rdata),
    .cmd_pop          (q_pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_head_valid   (out_head_valid),
    .out_head_due     (out_head_due),
    .out_head_handler (out_head_handler),
    .out_entry_count  (out_entry_count)
  );

`ifndef NO_ASSERTIONS
  // back end always passes through idle between results
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");

  // head flag tracks a nonzero count
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_entry_count != '0)))
    else $error("head valid disagrees with entry count");

  // a dropped push only happens on a full queue
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entry_count == CNT_W'(CAPACITY)))
    else $error("push dropped while queue not full");

  // pop on empty leaves the queue empty
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_entry_count == '0))
    else $error("empty pop reported with entries held");

  // no command is taken from the queue while the back end is forming a result
  a_no_pop_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(q_pop))
    else $error("command taken right before a result");
`endif

endmodule
